### hw/rtl/lsf_pkg.sv
package lsf_pkg;

  // data set size and field widths
  localparam int MAX_PAIRS = 65536;
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int SAMP_W    = 16;
  localparam int SX_W      = 33;
  localparam int SXX_W     = 47;
  localparam int SXY_W     = 48;
  localparam int RES_W     = 48;
  localparam int FRAC_W    = 16;

  // shared datapath widths
  localparam int MA_W      = 48;
  localparam int MB_W      = 33;
  localparam int NUM_W     = 80;
  localparam int DEN_W     = 64;
  localparam int ALU_W     = NUM_W + FRAC_W;
  localparam int DIV_STEPS = ALU_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [RES_W-1:0] SAT_POS = {1'b0, {(RES_W - 1){1'b1}}};
  localparam logic [RES_W-1:0] SAT_NEG = {1'b1, {(RES_W - 1){1'b0}}};

  // register index is the word address
  typedef enum logic {
    REG_SKIP_ZERO = 1'b0,
    REG_ABS_LIMIT = 1'b1
  } lsf_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LOAD,
    ST_MUL_STEP,
    ST_DIV_MAG,
    ST_DIV_HALF,
    ST_DIV_STEP,
    ST_DIV_END,
    ST_DONE
  } lsf_state_t;

  // product order: each odd entry is subtracted from the one before it
  typedef enum logic [2:0] {
    PROD_N_SXX,
    PROD_SX_SX,
    PROD_N_SXY,
    PROD_SX_SY,
    PROD_SXX_SY,
    PROD_SX_SXY
  } lsf_prod_t;

  typedef struct packed {
    logic        [CNT_W-1:0] n;
    logic signed [SX_W-1:0]  sx;
    logic signed [SX_W-1:0]  sy;
    logic        [SXX_W-1:0] sxx;
    logic signed [SXY_W-1:0] sxy;
  } lsf_sums_t;

  typedef struct packed {
    logic signed [RES_W-1:0] slope;
    logic signed [RES_W-1:0] intercept;
    logic                    degenerate;
  } lsf_result_t;

  function automatic logic [RES_W-1:0] sat_sign(input logic signed [NUM_W-1:0] v);
    logic [RES_W-1:0] r;
    if (v[NUM_W-1]) begin
      r = SAT_NEG;
    end else if (v == '0) begin
      r = '0;
    end else begin
      r = SAT_POS;
    end
    return r;
  endfunction

endpackage

### hw/rtl/least_squares_line_fit.sv
// least-squares straight-line fit over a stream of signed 16-bit (x, y) pairs
//
// input: a pair is taken at a clock edge with start high and busy low. a pair
//   that passes the zero filter and the |y| limit adds to the count and the
//   sums of x, y, x*x and x*y in that same cycle, so pairs without last can
//   arrive every cycle with no stall.
// fit: the pair marked last raises busy from the next cycle on. the fit runs
//   on one shared adder: six shift-add products (one step per multiplier bit,
//   at most 17 or 32 bits each), then two 96-step restoring divisions. when
//   the denominator is zero, the divisions are skipped.
// output: slope_out, intercept_out (Q31.16, saturated), used_count and
//   degenerate stand for exactly one cycle with done high. the receiver
//   cannot stall, so nothing waits; the sums clear at that edge.
// config: apb-style port, skip_zero at 0x0, abs_limit at 0x4; the user must
//   write them only while the block is idle (not enforced). pready is always high.
// reset: rst clears the registers, the count and all sums.
module least_squares_line_fit import lsf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [SAMP_W-1:0] x_value,
  input  logic signed [SAMP_W-1:0] y_value,
  input  logic                     last,
  output logic                     done,
  output logic signed [RES_W-1:0]  slope_out,
  output logic signed [RES_W-1:0]  intercept_out,
  output logic [CNT_W-1:0]         used_count,
  output logic                     degenerate,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic        skip_zero;
  logic [14:0] abs_limit;

  logic        [CNT_W-1:0] pair_count;
  logic signed [SX_W-1:0]  total_x;
  logic signed [SX_W-1:0]  total_y;
  logic        [SXX_W-1:0] total_xx;
  logic signed [SXY_W-1:0] total_xy;

  logic        fit_go;
  logic        eng_busy;
  logic        eng_done;
  lsf_sums_t   sums;
  lsf_result_t res;

  logic                        accept;
  logic                        keep;
  logic signed [SAMP_W:0]      y_ext;
  logic [SAMP_W:0]             abs_y;
  logic signed [2*SAMP_W-1:0]  xx_prod;
  logic signed [2*SAMP_W-1:0]  xy_prod;
  logic                        cfg_wr;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_zero <= 1'b0;
      abs_limit <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SKIP_ZERO: skip_zero <= pwdata[0];
        REG_ABS_LIMIT: abs_limit <= pwdata[14:0];
        default:       skip_zero <= skip_zero;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SKIP_ZERO: prdata = {31'b0, skip_zero};
      REG_ABS_LIMIT: prdata = {17'b0, abs_limit};
      default:       prdata = '0;
    endcase
  end

  // pair filters; |-32768| is 32768 and so never below the limit
  assign accept  = start & ~busy;
  assign y_ext   = (SAMP_W + 1)'(y_value);
  assign abs_y   = y_ext[SAMP_W] ? (SAMP_W + 1)'(-y_ext) : (SAMP_W + 1)'(y_ext);
  assign xx_prod = x_value * x_value;
  assign xy_prod = x_value * y_value;

  always_comb begin
    keep = 1'b1;
    if (skip_zero && (x_value == '0 || y_value == '0)) keep = 1'b0;
    if (abs_limit != '0 && abs_y >= (SAMP_W + 1)'(abs_limit)) keep = 1'b0;
    if (pair_count >= CNT_W'(MAX_PAIRS)) keep = 1'b0;
  end

  // accumulators, cleared as the result goes out
  always_ff @(posedge clk) begin
    if (rst || eng_done) begin
      pair_count <= '0;
      total_x    <= '0;
      total_y    <= '0;
      total_xx   <= '0;
      total_xy   <= '0;
    end else if (accept && keep) begin
      pair_count <= pair_count + CNT_W'(1);
      total_x    <= total_x + SX_W'(x_value);
      total_y    <= total_y + SX_W'(y_value);
      total_xx   <= total_xx + SXX_W'($unsigned(xx_prod));
      total_xy   <= total_xy + SXY_W'(xy_prod);
    end
  end

  // the fit starts from fit_go, registered after the last pair, so the sums are settled
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_go <= 1'b0;
    end else begin
      fit_go <= accept & last;
    end
  end

  assign sums.n   = pair_count;
  assign sums.sx  = total_x;
  assign sums.sy  = total_y;
  assign sums.sxx = total_xx;
  assign sums.sxy = total_xy;

  lsf_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (fit_go),
    .sums   (sums),
    .busy   (eng_busy),
    .done   (eng_done),
    .result (res)
  );

  assign busy          = fit_go | eng_busy;
  assign done          = eng_done;
  assign slope_out     = res.slope;
  assign intercept_out = res.intercept;
  assign degenerate    = res.degenerate;
  assign used_count    = pair_count;

  // the last pair always starts a fit
  a_last_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> busy)
    else $error("last pair did not start a fit");

  // sums are clear once a result has gone out
  a_clear_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> (pair_count == '0 && total_x == '0 && total_xx == '0))
    else $error("sums not cleared after result");

  // no new pair while the result beat is on the ports
  a_done_blocks_input: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("input open during result beat");

  // a degenerate fit gives only saturated or zero results
  a_degen_sat: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> ((slope_out == SAT_POS || slope_out == SAT_NEG
      || slope_out == '0) && (intercept_out == SAT_POS
      || intercept_out == SAT_NEG || intercept_out == '0)))
    else $error("degenerate fit not saturated");

endmodule

### hw/rtl/lsf_engine.sv
module lsf_engine import lsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  lsf_sums_t   sums,
  output logic        busy,
  output logic        done,
  output lsf_result_t result
);

  lsf_state_t state, state_next;
  lsf_prod_t  prod;
  logic       pass;

  logic [ALU_W-1:0] acc;
  logic [ALU_W-1:0] ma;
  logic [MB_W-1:0]  mb;
  logic             mul_neg;

  logic        [DEN_W-1:0] den_r;
  logic signed [NUM_W-1:0] nsl_r;
  logic signed [NUM_W-1:0] nin_r;

  logic [ALU_W-1:0]  dvd;
  logic [DEN_W-1:0]  rem;
  logic [RES_W-1:0]  quo;
  logic              quo_ovf;
  logic              num_neg;
  logic [STEP_W-1:0] step;

  logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
  logic             alu_cin;

  // operand selection for the current product
  logic signed [MA_W-1:0] op_a;
  logic signed [MB_W-1:0] op_b;
  logic                   prod_sub;
  logic                   b_neg;
  logic [MB_W-1:0]        b_mag;

  logic                    mul_last;
  logic [ALU_W-1:0]        acc_fin;
  logic signed [NUM_W-1:0] num_sel;
  logic signed [ALU_W-1:0] num_ext;
  logic [DEN_W:0]          div_t;
  logic                    div_ge;
  logic [RES_W-1:0]        quo_res;

  always_comb begin
    op_a     = '0;
    op_b     = '0;
    prod_sub = 1'b0;
    unique case (prod)
      PROD_N_SXX: begin
        op_a = MA_W'(sums.sxx);
        op_b = MB_W'(sums.n);
      end
      PROD_SX_SX: begin
        op_a     = MA_W'(sums.sx);
        op_b     = MB_W'(sums.sx);
        prod_sub = 1'b1;
      end
      PROD_N_SXY: begin
        op_a = MA_W'(sums.sxy);
        op_b = MB_W'(sums.n);
      end
      PROD_SX_SY: begin
        op_a     = MA_W'(sums.sx);
        op_b     = MB_W'(sums.sy);
        prod_sub = 1'b1;
      end
      PROD_SXX_SY: begin
        op_a = MA_W'(sums.sxx);
        op_b = MB_W'(sums.sy);
      end
      PROD_SX_SXY: begin
        op_a     = MA_W'(sums.sxy);
        op_b     = MB_W'(sums.sx);
        prod_sub = 1'b1;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    b_neg = op_b[MB_W-1];
    b_mag = b_neg ? MB_W'(-op_b) : MB_W'(op_b);
  end

  assign num_sel  = pass ? nin_r : nsl_r;
  assign num_ext  = ALU_W'(num_sel);
  assign div_t    = {rem, dvd[ALU_W-1]};
  assign mul_last = (mb[MB_W-1:1] == '0);

  // the one shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    unique case (state)
      ST_MUL_STEP: begin
        alu_a   = acc;
        alu_b   = mul_neg ? ~ma : ma;
        alu_cin = mul_neg;
      end
      ST_DIV_MAG: begin
        alu_b   = num_sel[NUM_W-1] ? ~num_ext : num_ext;
        alu_cin = num_sel[NUM_W-1];
      end
      ST_DIV_HALF: begin
        alu_a = {dvd[ALU_W-FRAC_W-1:0], FRAC_W'(0)};
        alu_b = ALU_W'(den_r >> 1);
      end
      ST_DIV_STEP: begin
        alu_a   = ALU_W'(div_t);
        alu_b   = ~ALU_W'(den_r);
        alu_cin = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_sum = alu_a + alu_b + ALU_W'(alu_cin);
  end

  assign acc_fin = mb[0] ? alu_sum : acc;
  assign div_ge  = ~alu_sum[ALU_W-1];

  // round-to-nearest quotient, signed and saturated
  always_comb begin
    if (num_neg) begin
      if (quo_ovf || (quo[RES_W-1] && (quo[RES_W-2:0] != '0))) begin
        quo_res = SAT_NEG;
      end else begin
        quo_res = RES_W'(0) - quo;
      end
    end else begin
      if (quo_ovf || quo[RES_W-1]) begin
        quo_res = SAT_POS;
      end else begin
        quo_res = quo;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (start) state_next = ST_MUL_LOAD;
      ST_MUL_LOAD: state_next = ST_MUL_STEP;
      ST_MUL_STEP: begin
        if (mul_last) begin
          if (prod != PROD_SX_SXY) begin
            state_next = ST_MUL_LOAD;
          end else if (den_r == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_DIV_MAG;
          end
        end
      end
      ST_DIV_MAG:  state_next = ST_DIV_HALF;
      ST_DIV_HALF: state_next = ST_DIV_STEP;
      ST_DIV_STEP: if (step == STEP_W'(DIV_STEPS - 1)) state_next = ST_DIV_END;
      ST_DIV_END:  state_next = pass ? ST_DONE : ST_DIV_MAG;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      prod  <= PROD_N_SXX;
      pass  <= 1'b0;
      step  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          prod <= PROD_N_SXX;
          pass <= 1'b0;
        end
        ST_MUL_STEP: if (mul_last && prod != PROD_SX_SXY) prod <= lsf_prod_t'(3'(prod) + 3'd1);
        ST_DIV_HALF: step <= '0;
        ST_DIV_STEP: step <= step + STEP_W'(1);
        ST_DIV_END:  pass <= 1'b1;
        default: begin
          step <= step;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_MUL_LOAD: begin
        if (!prod_sub) acc <= '0;
        ma      <= ALU_W'(op_a);
        mb      <= b_mag;
        mul_neg <= b_neg ^ prod_sub;
      end
      ST_MUL_STEP: begin
        acc <= acc_fin;
        ma  <= {ma[ALU_W-2:0], 1'b0};
        mb  <= mb >> 1;
        if (mul_last) begin
          unique case (prod)
            PROD_SX_SX: den_r <= acc_fin[DEN_W-1:0];
            PROD_SX_SY: nsl_r <= acc_fin[NUM_W-1:0];
            PROD_SX_SXY: begin
              nin_r                    <= acc_fin[NUM_W-1:0];
              result.slope             <= sat_sign(nsl_r);
              result.intercept         <= sat_sign(acc_fin[NUM_W-1:0]);
              result.degenerate        <= (den_r == '0);
            end
            default: begin
              den_r <= den_r;
            end
          endcase
        end
      end
      ST_DIV_MAG: begin
        dvd     <= alu_sum;
        num_neg <= num_sel[NUM_W-1];
      end
      ST_DIV_HALF: begin
        dvd     <= alu_sum;
        rem     <= '0;
        quo     <= '0;
        quo_ovf <= 1'b0;
      end
      ST_DIV_STEP: begin
        rem     <= div_ge ? alu_sum[DEN_W-1:0] : div_t[DEN_W-1:0];
        dvd     <= {dvd[ALU_W-2:0], 1'b0};
        quo     <= {quo[RES_W-2:0], div_ge};
        quo_ovf <= quo_ovf | quo[RES_W-1];
      end
      ST_DIV_END: begin
        if (pass) begin
          result.intercept <= quo_res;
        end else begin
          result.slope <= quo_res;
        end
        result.degenerate <= 1'b0;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

### verif/tb_least_squares_line_fit.sv
`timescale 1ns / 1ps

module tb_least_squares_line_fit;
  import lsf_pkg::*;

  // watchdog: cycles with no accepted pair, no fit out and no register access
  localparam int IDLE_LIMIT    = 5000;
  // pairs without last are absorbed in the accept cycle, so a short settle is plenty
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 340;
  localparam int WIDE_W        = 128;
  localparam int MAX_GAP       = 30;

  typedef struct {
    logic signed [RES_W-1:0] slope;
    logic signed [RES_W-1:0] intercept;
    logic [CNT_W-1:0]        count;
    logic                    degenerate;
  } line_fit_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic signed [SAMP_W-1:0] x_value;
  logic signed [SAMP_W-1:0] y_value;
  logic last;
  logic done;
  logic signed [RES_W-1:0] slope_out;
  logic signed [RES_W-1:0] intercept_out;
  logic [CNT_W-1:0] used_count;
  logic degenerate;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // fits still owed by the block, oldest first
  line_fit_t expected_fits[$];

  // mirror of the block's registers and running sums
  logic                    skip_zero_cfg;
  logic [14:0]             abs_limit_cfg;
  logic [CNT_W-1:0]        kept_count;
  logic signed [SX_W-1:0]  sum_x;
  logic signed [SX_W-1:0]  sum_y;
  logic [SXX_W-1:0]        sum_xx;
  logic signed [SXY_W-1:0] sum_xy;

  // run bookkeeping
  int idle_pct;
  int error_count;
  int pairs_sent;
  int pairs_kept;
  int fits_seen;
  int degenerate_seen;
  int quiet_cycles;

  least_squares_line_fit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .x_value      (x_value),
    .y_value      (y_value),
    .last         (last),
    .done         (done),
    .slope_out    (slope_out),
    .intercept_out(intercept_out),
    .used_count   (used_count),
    .degenerate   (degenerate),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // numerator * 2^16 / den, rounded half away from zero, clipped to 48 bits
  function automatic logic [RES_W-1:0] scaled_quotient(input logic signed [WIDE_W-1:0] num,
                                                       input logic [WIDE_W-1:0] den);
    logic [WIDE_W-1:0] mag;
    logic [WIDE_W-1:0] quo;
    logic [RES_W-1:0]  res;
    mag = num[WIDE_W-1] ? -num : num;
    quo = ((mag << FRAC_W) + (den >> 1)) / den;
    if (num[WIDE_W-1]) begin
      if (quo > {{(WIDE_W - RES_W){1'b0}}, SAT_NEG}) begin
        res = SAT_NEG;
      end else begin
        res = -quo[RES_W-1:0];
      end
    end else begin
      res = (quo > {{(WIDE_W - RES_W){1'b0}}, SAT_POS}) ? SAT_POS : quo[RES_W-1:0];
    end
    return res;
  endfunction

  // with no spread in x only the sign of the numerator survives
  function automatic logic [RES_W-1:0] clip_to_sign(input logic signed [WIDE_W-1:0] num);
    if (num < 0) begin
      return SAT_NEG;
    end else if (num == 0) begin
      return '0;
    end
    return SAT_POS;
  endfunction

  // filter one accepted pair into the sums; on last, solve the fit and clear
  task automatic fit_pair(input logic signed [SAMP_W-1:0] x, input logic signed [SAMP_W-1:0] y,
                          input logic lst);
    logic signed [31:0] xx;
    logic signed [31:0] xy;
    int abs_y;
    logic keep;
    logic signed [WIDE_W-1:0] wn, wx, wy, wxx, wxy;
    logic signed [WIDE_W-1:0] den, num_slope, num_icpt;
    line_fit_t fit;
    abs_y = (y < 0) ? -int'(y) : int'(y);
    keep = 1'b1;
    if (skip_zero_cfg && (x == 0 || y == 0)) keep = 1'b0;
    // most negative y counts as 32768 and so never passes an enabled limit
    if (abs_limit_cfg != 0 && abs_y >= int'(abs_limit_cfg)) keep = 1'b0;
    // counter at its ceiling: the rest of the data set is dropped
    if (int'(kept_count) >= MAX_PAIRS) keep = 1'b0;
    if (keep) begin
      xx = x * x;
      xy = x * y;
      sum_x = sum_x + x;
      sum_y = sum_y + y;
      sum_xx = sum_xx + xx;
      sum_xy = sum_xy + xy;
      kept_count = kept_count + 1'b1;
      pairs_kept++;
    end
    if (lst) begin
      wn = kept_count;
      wx = sum_x;
      wy = sum_y;
      wxx = sum_xx;
      wxy = sum_xy;
      den = wn * wxx - wx * wx;
      num_slope = wn * wxy - wx * wy;
      num_icpt = wxx * wy - wx * wxy;
      fit.count = kept_count;
      // an empty set or one with a single x lands here with zero numerators
      if (den == 0) begin
        fit.slope = clip_to_sign(num_slope);
        fit.intercept = clip_to_sign(num_icpt);
        fit.degenerate = 1'b1;
      end else begin
        fit.slope = scaled_quotient(num_slope, den);
        fit.intercept = scaled_quotient(num_icpt, den);
        fit.degenerate = 1'b0;
      end
      expected_fits.insert(expected_fits.size(), fit);
      kept_count = '0;
      sum_x = '0;
      sum_y = '0;
      sum_xx = '0;
      sum_xy = '0;
    end
  endtask

  // one pair beat: optional idle gap, then hold start until busy is low at an edge
  task automatic send_pair(input logic signed [SAMP_W-1:0] x, input logic signed [SAMP_W-1:0] y,
                           input logic lst);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    x_value <= x;
    y_value <= y;
    last <= lst;
    do @(posedge clk); while (busy);
    fit_pair(x, y, lst);
    pairs_sent++;
  endtask

  // drop start, let every owed fit come out, then a short quiet stretch
  task automatic wait_fits_done();
    @(negedge clk);
    start <= 1'b0;
    while (expected_fits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle then access cycle; the write lands at the edge with penable and pready
  task automatic write_reg(input lsf_reg_t idx, input logic [31:0] data);
    @(negedge clk);
    start <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * int'(idx));
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SKIP_ZERO: skip_zero_cfg = data[0];
      REG_ABS_LIMIT: abs_limit_cfg = data[14:0];
      default: ;
    endcase
  endtask

  // junk in the unused upper data bits must not reach the registers
  task automatic set_filters(input logic iz, input logic [14:0] lim);
    write_reg(REG_SKIP_ZERO, {31'($urandom()), iz});
    write_reg(REG_ABS_LIMIT, {17'($urandom()), lim});
  endtask

  // sample mix: zeros, rails, small values and full-range noise
  function automatic logic signed [SAMP_W-1:0] draw_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      2, 3: return 16'($urandom_range(200) - 100);
      default: return 16'($urandom());
    endcase
  endfunction

  // y near a random line through x, clamped to the sample range
  function automatic logic signed [SAMP_W-1:0] line_sample(input logic signed [SAMP_W-1:0] x,
                                                           input int gain, input int offs);
    int yv;
    yv = gain * int'(x) + offs + int'($urandom_range(20)) - 10;
    if (yv > 32767) yv = 32767;
    if (yv < -32768) yv = -32768;
    return 16'(yv);
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    // registers still at their reset values: no filtering
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    // single pair, no spread in x
    send_pair(16'sh0000, 16'sh0000, 1'b1);
    // vertical line
    send_pair(16'sd5, 16'sd100, 1'b0);
    send_pair(16'sd5, -16'sd200, 1'b0);
    send_pair(16'sd5, 16'sd7, 1'b1);
    // opposite rails plus ordinary points
    send_pair(16'sh8000, 16'sh7FFF, 1'b0);
    send_pair(16'sh7FFF, 16'sh8000, 1'b0);
    send_pair(16'sd0, 16'sd1, 1'b0);
    send_pair(16'sd100, -16'sd50, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b0);
    send_pair(16'sd2, 16'sd3, 1'b0);
    send_pair(-16'sd4, 16'sd0, 1'b1);
    wait_fits_done();
    // both filters on, widest limit: zero pairs, most negative y and |y| at the
    // limit are dropped, then a filtered last still closes the set
    set_filters(1'b1, 15'h7FFF);
    send_pair(16'sd0, 16'sd5, 1'b0);
    send_pair(16'sd3, 16'sd0, 1'b0);
    send_pair(16'sd7, 16'sh8000, 1'b0);
    send_pair(16'sd7, 16'sd32766, 1'b0);
    send_pair(-16'sd9, -16'sd32767, 1'b0);
    send_pair(16'sd2, -16'sd100, 1'b0);
    send_pair(16'sd0, 16'sd9, 1'b1);
    // empty data set
    send_pair(16'sd0, 16'sd0, 1'b1);
    wait_fits_done();
    // tightest limit: only y == 0 gets through
    set_filters(1'b0, 15'd1);
    send_pair(16'sd4, 16'sd0, 1'b0);
    send_pair(-16'sd3, 16'sd0, 1'b0);
    send_pair(16'sd8, 16'sd1, 1'b1);
    wait_fits_done();
  endtask

  // random data sets of random length under one filter setting and idle rate
  task automatic test_random_sets(input int pct, input logic iz, input logic [14:0] lim);
    int left;
    int len;
    int gain;
    int offs;
    logic on_line;
    logic signed [SAMP_W-1:0] x;
    logic signed [SAMP_W-1:0] y;
    set_filters(iz, lim);
    idle_pct = pct;
    left = PHASE_ITEMS;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(200, 1) : $urandom_range(40, 1);
      if (len > left) len = left;
      on_line = $urandom_range(1);
      gain = $urandom_range(8) - 4;
      offs = $urandom_range(2000) - 1000;
      for (int i = 0; i < len; i++) begin
        if (on_line) begin
          x = 16'($urandom_range(16000) - 8000);
          y = line_sample(x, gain, offs);
        end else begin
          x = draw_sample();
          y = draw_sample();
        end
        send_pair(x, y, i == len - 1);
      end
      left -= len;
    end
    wait_fits_done();
  endtask

  // compare every fit beat against the oldest owed fit, field by field
  always @(posedge clk) begin
    line_fit_t want;
    if (!rst && done) begin
      fits_seen++;
      if (degenerate) degenerate_seen++;
      if (expected_fits.size() == 0) begin
        $error("fit beat with nothing owed: slope %0d intercept %0d count %0d",
               slope_out, intercept_out, used_count);
        error_count++;
      end else begin
        want = expected_fits.pop_front();
        if (slope_out !== want.slope) begin
          $error("slope_out: expected %0d, got %0d", want.slope, slope_out);
          error_count++;
        end
        if (intercept_out !== want.intercept) begin
          $error("intercept_out: expected %0d, got %0d", want.intercept, intercept_out);
          error_count++;
        end
        if (used_count !== want.count) begin
          $error("used_count: expected %0d, got %0d", want.count, used_count);
          error_count++;
        end
        if (degenerate !== want.degenerate) begin
          $error("degenerate: expected %0d, got %0d", want.degenerate, degenerate);
          error_count++;
        end
      end
    end
  end

  // hang detection: any beat or register access restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    x_value = '0;
    y_value = '0;
    last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    error_count = 0;
    pairs_sent = 0;
    pairs_kept = 0;
    fits_seen = 0;
    degenerate_seen = 0;
    quiet_cycles = 0;
    skip_zero_cfg = 1'b0;
    abs_limit_cfg = '0;
    kept_count = '0;
    sum_x = '0;
    sum_y = '0;
    sum_xx = '0;
    sum_xy = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    // idle rates cycle through none, heavy and light; filters go to both ends
    test_random_sets(0, 1'b0, 15'd0);
    test_random_sets(46, 1'b1, 15'h7FFF);
    test_random_sets(8, 1'b0, 15'd1);
    test_random_sets(0, 1'b1, 15'd0);
    test_random_sets(46, 1'b0, 15'($urandom_range(32767, 1)));
    test_random_sets(8, 1'($urandom()), 15'($urandom_range(32767, 1)));
    wait_fits_done();

    if (expected_fits.size() != 0) begin
      $error("%0d fits never came out", expected_fits.size());
      error_count++;
    end
    $display("sent %0d pairs, %0d kept by the filters; %0d fits checked, %0d degenerate",
             pairs_sent, pairs_kept, fits_seen, degenerate_seen);
    $display("filters at both extremes, empty and single-x sets, idle rates 0/46/8 percent");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
